// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only while out of reset
`define IWBF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define IWBF_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define IWBF_ASSERT(label, clk, rst_n, prop, msg)
`define IWBF_ASSERT_NR(label, clk, prop, msg)

`endif

`endif

// ===== sv/iwbf_pkg.sv =====
// ----------------------------------------------------------------------------
// iwbf_pkg
// Shared constants, codes and types of the image window border fetch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package iwbf_pkg;

    // image store geometry
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WINDOW = 7;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);

    // field widths
    localparam int POS_W    = 10;           // signed input coordinate
    localparam int COORD_W  = POS_W + 1;    // window coordinate, centre +- half
    localparam int MAG_W    = COORD_W - 1;  // magnitude of a window coordinate
    localparam int STEP_W   = $clog2(MAG_W);
    localparam int DIM_W    = 9;            // width / height registers
    localparam int WIN_W    = 3;
    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int TDATA_W  = 48;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 3;

    // effective dimension limits, saturated to what the registers can hold
    localparam logic [DIM_W-1:0] W_CAP =
        DIM_W'((MAX_WIDTH > 511) ? 511 : MAX_WIDTH);
    localparam logic [DIM_W-1:0] H_CAP =
        DIM_W'((MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT);
    localparam logic [WIN_W-1:0] HALF_MAX = WIN_W'((MAX_WINDOW - 1) / 2);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MODE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GRAY_FORMAT    = 3'd5;

    // border modes; any other code clamps
    localparam logic [1:0] EDGE_WRAP  = 2'd0;
    localparam logic [1:0] EDGE_ZERO  = 2'd1;
    localparam logic [1:0] EDGE_CLAMP = 2'd2;

    // channels
    localparam logic [1:0] CH_LUMA  = 2'd0;
    localparam logic [1:0] CH_RED   = 2'd1;
    localparam logic [1:0] CH_GREEN = 2'd2;
    localparam logic [1:0] CH_BLUE  = 2'd3;

    // item kinds
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_WINDOW = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] value;
        logic            last;
    } t_sample;

endpackage

`default_nettype wire

// ===== sv/iwbf_ram.sv =====
// ----------------------------------------------------------------------------
// iwbf_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module iwbf_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/image_window_border_fetch.sv =====
// ----------------------------------------------------------------------------
// image_window_border_fetch
// RGB image store with windowed read-out and wrap / zero / clamp borders.
// ----------------------------------------------------------------------------
// A write beat (tuser 0) stores one pixel; writes outside the configured
// image are dropped. A window beat (tuser 1) streams the side x side
// neighbourhood of the centre, column-major (x outer, y inner), one
// sample per cycle while the output is taken, tlast on the final one.
// The single RAM port gives one pixel read a cycle. In wrap mode the walk
// is preceded by the bit-serial remainder of the start column and row and
// then the fix for negative coordinates. The input is not ready while a
// window is being fetched. Pixels read out must have been written first;
// the store has no reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module image_window_border_fetch
    import iwbf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [TDATA_W-1:0]   s_axis_tdata,  // pos_x, pos_y, pixel_rgb, pad
    input  wire logic                 s_axis_tuser,  // action
    // sample stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [CH_W-1:0]           m_axis_tdata,  // sample_value
    output logic                      m_axis_tlast   // last_sample
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_FIX  = 4'b0100,
        S_RUN  = 4'b1000
    } t_state;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;
    logic [1:0]       r_edge, r_chan;
    logic [WIN_W-1:0] r_wsize;
    logic             r_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= DIM_W'(256);
            r_cfg_h <= DIM_W'(256);
            r_edge  <= EDGE_CLAMP;
            r_chan  <= CH_LUMA;
            r_wsize <= WIN_W'(3);
            r_gray  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:    r_cfg_w <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT:   r_cfg_h <= i_cfg_data[DIM_W-1:0];
                REG_EDGE_MODE:      r_edge  <= i_cfg_data[1:0];
                REG_CHANNEL_SELECT: r_chan  <= i_cfg_data[1:0];
                REG_WINDOW_SIZE:    r_wsize <= i_cfg_data[WIN_W-1:0];
                REG_GRAY_FORMAT:    r_gray  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective image size and window geometry
    logic [DIM_W-1:0] w_eff, h_eff;
    logic [WIN_W-1:0] half, last_idx;

    always_comb begin
        if (r_cfg_w == '0)        w_eff = DIM_W'(1);
        else if (r_cfg_w > W_CAP) w_eff = W_CAP;
        else                      w_eff = r_cfg_w;
        if (r_cfg_h == '0)        h_eff = DIM_W'(1);
        else if (r_cfg_h > H_CAP) h_eff = H_CAP;
        else                      h_eff = r_cfg_h;
        half = r_wsize >> 1;
        if (half > HALF_MAX) half = HALF_MAX;
        last_idx = WIN_W'(half << 1);
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [DIM_W-1:0] f_wrap_inc(input logic [DIM_W-1:0] v,
                                                    input logic [DIM_W-1:0] n);
        logic [DIM_W-1:0] s;
        s = v + DIM_W'(1);
        return (s == n) ? '0 : s;
    endfunction

    function automatic logic [DIM_W-1:0] f_clamp(input logic signed [COORD_W-1:0] c,
                                                 input logic [DIM_W-1:0] n);
        logic signed [COORD_W-1:0] n_s;
        n_s = $signed({2'b00, n});
        if (c < 0)         return '0;
        else if (c >= n_s) return n - DIM_W'(1);
        else               return c[DIM_W-1:0];
    endfunction

    // one restoring-division step of the remainder
    function automatic logic [DIM_W-1:0] f_rem_step(input logic [DIM_W-1:0] rem,
                                                    input logic             bit_in,
                                                    input logic [DIM_W-1:0] n);
        logic [DIM_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, n}) return DIM_W'(t - {1'b0, n});
        else                return t[DIM_W-1:0];
    endfunction

    function automatic logic [CH_W-1:0] f_channel(input logic [PIX_W-1:0] p,
                                                  input logic             gray,
                                                  input logic [1:0]       ch);
        logic [12:0] luma;
        luma = 13'(p[23:16]) * 13'd11 + 13'(p[15:8]) * 13'd16 + 13'(p[7:0]) * 13'd5;
        if (gray) begin
            return (ch == CH_LUMA) ? luma[12:5] : '0;
        end
        case (ch)
            CH_RED:   return p[23:16];
            CH_GREEN: return p[15:8];
            CH_BLUE:  return p[7:0];
            default:  return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // input beat
    // ------------------------------------------------------------------
    logic                      in_act;
    logic signed [POS_W-1:0]   in_px, in_py;
    logic [PIX_W-1:0]          in_pix;
    logic                      in_acc;

    assign in_act = s_axis_tuser;
    assign in_px  = $signed(s_axis_tdata[POS_W-1:0]);
    assign in_py  = $signed(s_axis_tdata[2*POS_W-1:POS_W]);
    assign in_pix = s_axis_tdata[2*POS_W+PIX_W-1:2*POS_W];

    t_state r_state, n_state;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // walk state
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] r_rx, r_ry, r_ry0, n_rx, n_ry, n_ry0;
    logic [DIM_W-1:0]          r_wx, r_wy, r_wy0, n_wx, n_wy, n_wy0;
    logic [WIN_W-1:0]          r_ix, r_iy, n_ix, n_iy;
    logic [MAG_W-1:0]          r_magx, r_magy, n_magx, n_magy;
    logic [DIM_W-1:0]          r_remx, r_remy, n_remx, n_remy;
    logic                      r_negx, r_negy, n_negx, n_negy;
    logic [STEP_W-1:0]         r_step, n_step;

    // read issue / output queue
    logic              r_pend, r_pend_last, r_pend_zero;
    logic [1:0]        r_cnt, n_cnt;
    t_sample           r_q0, r_q1, n_q0, n_q1, arr;
    logic              pop, issue, iss_last;
    logic [2:0]        occ;

    // RAM
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr, rd_addr, wr_addr;
    logic [PIX_W-1:0]  ram_rdata;

    // read coordinate for the current element
    logic [DIM_W-1:0]  rd_x, rd_y;
    logic              rd_zero;

    always_comb begin
        rd_zero = 1'b0;
        case (r_edge)
            EDGE_WRAP: begin
                rd_x = r_wx;
                rd_y = r_wy;
            end
            EDGE_ZERO: begin
                rd_x = r_rx[DIM_W-1:0];
                rd_y = r_ry[DIM_W-1:0];
                rd_zero = (r_rx < 0) || (r_rx >= $signed({2'b00, w_eff})) ||
                          (r_ry < 0) || (r_ry >= $signed({2'b00, h_eff}));
            end
            default: begin
                rd_x = f_clamp(r_rx, w_eff);
                rd_y = f_clamp(r_ry, h_eff);
            end
        endcase
    end

    assign rd_addr = ADDR_W'(rd_y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(rd_x);
    assign wr_addr = ADDR_W'(in_py[DIM_W-1:0]) * ADDR_W'(MAX_WIDTH)
                   + ADDR_W'(in_px[DIM_W-1:0]);

    assign ram_we = in_acc && (in_act == ACT_WRITE) &&
                    !in_px[POS_W-1] && (in_px[DIM_W-1:0] < w_eff) &&
                    !in_py[POS_W-1] && (in_py[DIM_W-1:0] < h_eff);
    assign ram_addr = ram_we ? wr_addr : rd_addr;

    iwbf_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (in_pix),
        .o_rdata (ram_rdata)
    );

    // issue a read only if its sample will find a queue slot
    assign pop      = m_axis_tvalid && m_axis_tready;
    assign occ      = 3'(r_cnt) + 3'(r_pend) - 3'(pop);
    assign issue    = (r_state == S_RUN) && (occ < 3'd2);
    assign iss_last = issue && (r_ix == last_idx) && (r_iy == last_idx);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] x0, y0;

    always_comb begin
        x0 = COORD_W'(in_px) - $signed({1'b0, half});
        y0 = COORD_W'(in_py) - $signed({1'b0, half});

        n_state = r_state;
        n_rx = r_rx;   n_ry = r_ry;   n_ry0 = r_ry0;
        n_wx = r_wx;   n_wy = r_wy;   n_wy0 = r_wy0;
        n_ix = r_ix;   n_iy = r_iy;
        n_magx = r_magx; n_magy = r_magy;
        n_remx = r_remx; n_remy = r_remy;
        n_negx = r_negx; n_negy = r_negy;
        n_step = r_step;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (in_act == ACT_WINDOW)) begin
                    n_rx   = x0;
                    n_ry   = y0;
                    n_ry0  = y0;
                    n_ix   = '0;
                    n_iy   = '0;
                    n_negx = x0[COORD_W-1];
                    n_negy = y0[COORD_W-1];
                    n_magx = x0[COORD_W-1] ? MAG_W'(-x0) : x0[MAG_W-1:0];
                    n_magy = y0[COORD_W-1] ? MAG_W'(-y0) : y0[MAG_W-1:0];
                    n_remx = '0;
                    n_remy = '0;
                    n_step = '0;
                    n_state = (r_edge == EDGE_WRAP) ? S_MOD : S_RUN;
                end
            end
            S_MOD: begin
                // MSB first, one bit of each magnitude per cycle
                n_remx = f_rem_step(r_remx, r_magx[MAG_W-1], w_eff);
                n_remy = f_rem_step(r_remy, r_magy[MAG_W-1], h_eff);
                n_magx = r_magx << 1;
                n_magy = r_magy << 1;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(MAG_W - 1)) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                // true modulo for negative starts
                n_wx  = (r_negx && (r_remx != '0)) ? w_eff - r_remx : r_remx;
                n_wy  = (r_negy && (r_remy != '0)) ? h_eff - r_remy : r_remy;
                n_wy0 = n_wy;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (issue) begin
                    if (r_iy == last_idx) begin
                        n_iy = '0;
                        n_ry = r_ry0;
                        n_wy = r_wy0;
                        n_ix = r_ix + WIN_W'(1);
                        n_rx = r_rx + COORD_W'(1);
                        n_wx = f_wrap_inc(r_wx, w_eff);
                        if (r_ix == last_idx) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_iy = r_iy + WIN_W'(1);
                        n_ry = r_ry + COORD_W'(1);
                        n_wy = f_wrap_inc(r_wy, h_eff);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output queue: two slots, head drives the port
    always_comb begin
        arr.value = r_pend_zero ? '0 : f_channel(ram_rdata, r_gray, r_chan);
        arr.last  = r_pend_last;
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = 2'(3'(r_cnt) + 3'(r_pend) - 3'(pop));
        if (pop) begin
            if (r_cnt == 2'd2) begin
                n_q0 = r_q1;
                if (r_pend) n_q1 = arr;
            end else if (r_pend) begin
                n_q0 = arr;
            end
        end else if (r_pend) begin
            if (r_cnt == 2'd0) n_q0 = arr;
            else               n_q1 = arr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= issue;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx   <= n_rx;   r_ry   <= n_ry;   r_ry0 <= n_ry0;
        r_wx   <= n_wx;   r_wy   <= n_wy;   r_wy0 <= n_wy0;
        r_ix   <= n_ix;   r_iy   <= n_iy;
        r_magx <= n_magx; r_magy <= n_magy;
        r_remx <= n_remx; r_remy <= n_remy;
        r_negx <= n_negx; r_negy <= n_negy;
        r_step <= n_step;
        r_pend_last <= iss_last;
        r_pend_zero <= rd_zero;
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q0.value;
    assign m_axis_tlast  = r_q0.last;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `IWBF_ASSERT(a_queue_room, i_clk, i_rst_n, !(r_cnt == 2'd2 && r_pend), "queue overrun")
    `IWBF_ASSERT(a_no_write_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> !ram_we, "busy write")
    `IWBF_ASSERT(a_last_ends, i_clk, i_rst_n, iss_last |=> (r_state == S_IDLE), "walk overran")
    `IWBF_ASSERT(a_remx_range, i_clk, i_rst_n, (r_state == S_FIX) |-> r_remx < w_eff, "bad remainder")
    `IWBF_ASSERT(a_remy_range, i_clk, i_rst_n, (r_state == S_FIX) |-> r_remy < h_eff, "bad remainder")

endmodule

`default_nettype wire

// ===== bench/tb_image_window_border_fetch.sv =====
// ----------------------------------------------------------------------------
// tb_image_window_border_fetch
// Self-checking bench for the windowed image fetch with border handling.
// ----------------------------------------------------------------------------
// Pixels are loaded through write beats and whole windows are requested
// through window beats. The bench mirrors the pixel store and register set
// and works out every sample of a window when the request beat is taken. It
// then compares the sample stream beat by beat, data and tlast, against that
// queue. Before each window, every pixel that the window will touch and that
// has never been stored is written first, so undefined store contents are
// never read. Border modes, channels, gray and RGB formats, window sizes and
// out-of-range dimensions are covered by short directed tests, then by
// random phases. Random gaps on the input and random stalls on the output
// alternate with stretches at full rate.
`timescale 1ns / 1ps

module tb_image_window_border_fetch;
    import iwbf_pkg::*;

    localparam logic [1:0] EDGE_SPARE = 2'd3;   // undefined code, must clamp
    localparam int STORE_ROW     = MAX_WIDTH;
    localparam int SETTLE_CYCLES = 20;
    localparam int QUIET_LIMIT   = 1000;
    localparam int ITEM_TARGET   = 160;          // input beats over the whole run
    localparam int PHASE_ITEMS   = 20;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;   // pos_x, pos_y, pixel_rgb, pad
    logic                 s_axis_tuser  = 1'b0; // action
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [CH_W-1:0]      m_axis_tdata;         // sample_value
    logic                 m_axis_tlast;         // last_sample

    image_window_border_fetch uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // mirror of the store and the registers
    logic [PIX_W-1:0] pixel_shadow [DEPTH];
    bit               pixel_known  [DEPTH];
    logic [DIM_W-1:0] img_w_reg  = 9'd256;
    logic [DIM_W-1:0] img_h_reg  = 9'd256;
    logic [1:0]       edge_reg   = EDGE_CLAMP;
    logic [1:0]       chan_reg   = CH_LUMA;
    logic [WIN_W-1:0] win_reg    = 3'd3;
    logic             gray_reg   = 1'b0;

    t_sample window_samples [$];
    bit      calm         = 1'b0;
    int      n_fail       = 0;
    int      n_items      = 0;
    int      quiet_cycles = 0;
    int      rx_hold      = 0;

    function automatic int eff_dim(logic [DIM_W-1:0] v, int cap);
        if (v == '0) return 1;
        if (int'(v) > cap) return cap;
        return int'(v);
    endfunction

    function automatic int half_side();
        int hs;
        hs = int'(win_reg >> 1);
        return (hs > (MAX_WINDOW - 1) / 2) ? (MAX_WINDOW - 1) / 2 : hs;
    endfunction

    // store address that a window coordinate resolves to; -1 for a black pixel
    function automatic int border_addr(int x, int y, int w, int h);
        int cx;
        int cy;
        cx = x;
        cy = y;
        if (edge_reg == EDGE_WRAP) begin
            cx = ((x % w) + w) % w;
            cy = ((y % h) + h) % h;
        end else if (edge_reg == EDGE_ZERO) begin
            if (x < 0 || x >= w || y < 0 || y >= h) return -1;
        end else begin
            cx = (x < 0) ? 0 : (x >= w) ? w - 1 : x;
            cy = (y < 0) ? 0 : (y >= h) ? h - 1 : y;
        end
        return cy * STORE_ROW + cx;
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return DIM_W'(MAX_WIDTH);
            2:       return DIM_W'($urandom_range(257, 511));
            3:       return DIM_W'($urandom_range(13, 255));
            default: return DIM_W'($urandom_range(1, 12));
        endcase
    endfunction

    // one beat into the block; the mirror is updated when it is taken
    task automatic send_beat(logic act, int x, int y, logic [PIX_W-1:0] rgb);
        int gap;
        int w;
        int h;
        int hs;
        int a;
        int total;
        int n;
        int r;
        int g;
        int b;
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic [PIX_W-1:0] p;
        logic [CH_W-1:0] v;
        t_sample s;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        sx = x[POS_W-1:0];
        sy = y[POS_W-1:0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= TDATA_W'({rgb, sy, sx});
        do @(posedge i_clk); while (!s_axis_tready);
        n_items++;

        w = eff_dim(img_w_reg, MAX_WIDTH);
        h = eff_dim(img_h_reg, MAX_HEIGHT);
        x = sx;
        y = sy;
        if (act == ACT_WRITE) begin
            if (x >= 0 && x < w && y >= 0 && y < h) begin
                pixel_shadow[y * STORE_ROW + x] = rgb;
                pixel_known[y * STORE_ROW + x]  = 1'b1;
            end
        end else begin
            hs    = half_side();
            total = (2 * hs + 1) * (2 * hs + 1);
            n     = 0;
            for (int i = x - hs; i <= x + hs; i++) begin
                for (int q = y - hs; q <= y + hs; q++) begin
                    a = border_addr(i, q, w, h);
                    p = (a < 0) ? '0 : pixel_shadow[a];
                    r = p[23:16];
                    g = p[15:8];
                    b = p[7:0];
                    if (gray_reg) begin
                        v = (chan_reg == CH_LUMA) ? CH_W'((r * 11 + g * 16 + b * 5) >> 5) : '0;
                    end else begin
                        case (chan_reg)
                            CH_RED:   v = CH_W'(r);
                            CH_GREEN: v = CH_W'(g);
                            CH_BLUE:  v = CH_W'(b);
                            default:  v = '0;
                        endcase
                    end
                    n++;
                    s.value = v;
                    s.last  = (n == total);
                    window_samples.push_back(s);
                end
            end
        end
    endtask

    // loads any pixel the window touches that was never stored, then asks for it
    task automatic send_window(int x, int y);
        int w;
        int h;
        int hs;
        int a;
        w  = eff_dim(img_w_reg, MAX_WIDTH);
        h  = eff_dim(img_h_reg, MAX_HEIGHT);
        hs = half_side();
        for (int i = x - hs; i <= x + hs; i++) begin
            for (int q = y - hs; q <= y + hs; q++) begin
                a = border_addr(i, q, w, h);
                if (a >= 0 && !pixel_known[a])
                    send_beat(ACT_WRITE, a % STORE_ROW, a / STORE_ROW, PIX_W'($urandom));
            end
        end
        send_beat(ACT_WINDOW, x, y, PIX_W'($urandom));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (window_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    task automatic apply_config(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                logic [1:0] edge_m, logic [1:0] ch,
                                logic [WIN_W-1:0] win, logic gray);
        settle();
        write_reg(REG_IMAGE_WIDTH,    CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT,   CFG_W'(h));
        write_reg(REG_EDGE_MODE,      CFG_W'(edge_m));
        write_reg(REG_CHANNEL_SELECT, CFG_W'(ch));
        write_reg(REG_WINDOW_SIZE,    CFG_W'(win));
        write_reg(REG_GRAY_FORMAT,    CFG_W'(gray));
        i_cfg_we  <= 1'b0;
        img_w_reg = w;
        img_h_reg = h;
        edge_reg  = edge_m;
        chan_reg  = ch;
        win_reg   = win;
        gray_reg  = gray;
    endtask

    // reset values: 256 x 256, clamp, luma on an RGB image, so all zero
    task automatic test_reset_defaults();
        send_window(0, 0);
        send_window(-512, 511);
    endtask

    task automatic test_ignored_writes();
        apply_config(9'd256, 9'd256, EDGE_CLAMP, CH_RED, 3'd1, 1'b0);
        send_beat(ACT_WRITE, 3, 3, 24'hA1B2C3);
        send_beat(ACT_WRITE, -1, 3, 24'hFFFFFF);
        send_beat(ACT_WRITE, 256, 0, 24'h00FF00);
        send_beat(ACT_WRITE, 3, -512, 24'hFF0000);
        send_beat(ACT_WRITE, 511, 511, 24'h0000FF);
        apply_config(9'd2, 9'd256, EDGE_CLAMP, CH_RED, 3'd1, 1'b0);
        send_beat(ACT_WRITE, 3, 3, 24'h5A5A5A);   // column beyond the narrowed image
        apply_config(9'd256, 9'd256, EDGE_CLAMP, CH_RED, 3'd1, 1'b0);
        send_window(3, 3);
    endtask

    // full 7 x 7 window over a 3 x 2 image crosses every border
    task automatic test_border_modes();
        logic [1:0] modes [4];
        logic [1:0] chans [4];
        modes = '{EDGE_WRAP, EDGE_ZERO, EDGE_CLAMP, EDGE_SPARE};
        chans = '{CH_GREEN, CH_BLUE, CH_RED, CH_GREEN};
        calm = 1'b1;
        for (int k = 0; k < 4; k++) begin
            apply_config(9'd3, 9'd2, modes[k], chans[k], 3'd7, 1'b0);
            send_window(0, 1);
        end
        calm = 1'b0;
    endtask

    task automatic test_channels();
        apply_config(9'd2, 9'd2, EDGE_CLAMP, CH_BLUE, 3'd3, 1'b0);
        send_window(1, 1);
        apply_config(9'd2, 9'd2, EDGE_CLAMP, CH_LUMA, 3'd3, 1'b1);
        send_window(1, 1);
        apply_config(9'd2, 9'd2, EDGE_CLAMP, CH_GREEN, 3'd3, 1'b1);
        send_window(1, 1);
    endtask

    // zero dimensions act as one, oversized ones as the maximum; even sides round up
    task automatic test_dimension_extremes();
        apply_config(9'd0, 9'd0, EDGE_WRAP, CH_RED, 3'd0, 1'b0);
        send_window(200, -300);
        apply_config(9'd511, 9'd511, EDGE_WRAP, CH_BLUE, 3'd2, 1'b0);
        send_window(0, 0);
        apply_config(9'd2, 9'd1, EDGE_ZERO, CH_GREEN, 3'd6, 1'b0);
        send_window(1, 0);
    endtask

    // random phases until the run has sent its share of input beats
    task automatic test_random_traffic();
        int w;
        int h;
        int start_items;
        int cx;
        int cy;
        logic [DIM_W-1:0] wd;
        logic [DIM_W-1:0] ht;
        for (int ph = 0; ph < 8 && n_items < ITEM_TARGET; ph++) begin
            wd = pick_dim();
            ht = pick_dim();
            apply_config(wd, ht, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                         3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            calm        = ($urandom_range(0, 3) == 0);
            w           = eff_dim(img_w_reg, MAX_WIDTH);
            h           = eff_dim(img_h_reg, MAX_HEIGHT);
            start_items = n_items;
            while (n_items - start_items < PHASE_ITEMS && n_items < ITEM_TARGET) begin
                if ($urandom_range(0, 4) == 0) begin
                    cx = int'($urandom_range(0, 1023)) - 512;
                    cy = int'($urandom_range(0, 1023)) - 512;
                end else if ($urandom_range(0, 9) < 7) begin
                    cx = int'($urandom_range(0, w + 7)) - 4;
                    cy = int'($urandom_range(0, h + 7)) - 4;
                end else begin
                    cx = int'($urandom_range(0, w - 1));
                    cy = int'($urandom_range(0, h - 1));
                end
                if ($urandom_range(0, 9) < 7) begin
                    send_window(cx, cy);
                end else begin
                    send_beat(ACT_WRITE, cx, cy, PIX_W'($urandom));
                end
            end
        end
        calm = 1'b0;
    endtask

    // output side: random stall after every beat taken, none while calm
    always @(posedge i_clk) begin : sample_sink
        int stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_hold       <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall = calm ? 0 : $urandom_range(0, 14);
            rx_hold       <= stall;
            m_axis_tready <= (stall == 0);
        end else if (rx_hold > 0) begin
            rx_hold       <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : sample_check
        t_sample want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (window_samples.size() == 0) begin
                if (n_fail < 10)
                    $display("unexpected sample %02h last %0b", m_axis_tdata, m_axis_tlast);
                n_fail++;
            end else begin
                want = window_samples.pop_front();
                if (m_axis_tdata !== want.value || m_axis_tlast !== want.last) begin
                    if (n_fail < 10)
                        $display("sample mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.value, want.last, m_axis_tdata, m_axis_tlast);
                    n_fail++;
                end
            end
        end
    end

    // ends a hung run: nothing taken on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_ignored_writes();
        test_border_modes();
        test_channels();
        test_dimension_extremes();
        test_random_traffic();
        settle();
        if (n_fail == 0 && window_samples.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
